// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define UAM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define UAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/uam_pkg.sv -----
// Package of the usage alarm monitor: widths, reset values, register indexes,
// sequencer states and the divider status type. No dependencies.
`default_nettype none

package uam_pkg;

  localparam int USED_W      = 32;
  localparam int USAGE_W     = 15;
  localparam int LEVEL_W     = 7;
  localparam int CAP_W       = 8;
  localparam int SAMP_W      = 16;
  localparam int STAT_W      = 16;
  localparam int SUM_W       = 31;
  localparam int DIV_NUM_W   = USED_W + USAGE_W;
  localparam int DIV_STEPS   = USAGE_W;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 112;
  localparam int OUT_USER_W  = 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int COUNT_BITS_DEF = 16;

  localparam logic [USAGE_W-1:0] FULL_SCALE = 15'd25600;

  localparam logic [LEVEL_W-1:0] ALARM_LEVEL_RST  = 7'd90;
  localparam logic [LEVEL_W-1:0] RESUME_LEVEL_RST = 7'd80;
  localparam logic [CAP_W-1:0]   REPORT_CAP_RST   = 8'd9;
  localparam logic [SAMP_W-1:0]  SILENCE_RST      = 16'd6;
  localparam logic [SAMP_W-1:0]  STAT_SAMPLES_RST = 16'd360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALARM_LEVEL  = 3'd0,
    CFG_RESUME_LEVEL = 3'd1,
    CFG_REPORT_CAP   = 3'd2,
    CFG_SILENCE      = 3'd3,
    CFG_STAT_SAMPLES = 3'd4
  } uam_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_QSTART,
    ST_QWAIT,
    ST_UPDATE,
    ST_ASTART,
    ST_AWAIT,
    ST_WRITE
  } uam_state_t;

  typedef struct packed {
    logic               done;
    logic [USAGE_W-1:0] quot;
  } uam_div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/usage_alarm_monitor_with_stats.sv -----
// Usage alarm monitor with hysteresis and periodic statistics.
// States per sample: MUL, QSTART, QWAIT, UPDATE, WRITE; at or above 100 percent
// QWAIT is skipped, and a period close adds ASTART, AWAIT for the average. No new
// sample is taken until WRITE loads the output; zero samples are dropped in IDLE.
// The shared 15-step divider serves the usage quotient, then the period average.
// Reset (synchronous, rst_n low): registers to defaults, alarm idle, stats cleared.
`default_nettype none

module usage_alarm_monitor_with_stats #(
  parameter int COUNT_BITS = uam_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: used_count [31:0], total_count [63:32]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [uam_pkg::IN_DATA_W-1:0]   in_tdata,
  // out_tdata: usage_pct [14:0], alarm_active [15], alarm_report [16],
  //   resume_event [17], min_usage [32:18], max_usage [47:33],
  //   avg_usage [62:48], raise_total [78:63], resume_total [94:79],
  //   alarm_duration [110:95], zero pad [111]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [uam_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: stat_report [0]
  output logic [uam_pkg::OUT_USER_W-1:0]  out_tuser,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [uam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uam_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import uam_pkg::*;

  localparam int ExtW = (COUNT_BITS > STAT_W) ? COUNT_BITS : STAT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes are always taken.
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] alarm_lvl_r;
  logic [LEVEL_W-1:0] resume_lvl_r;
  logic [CAP_W-1:0]   report_cap_r;
  logic [SAMP_W-1:0]  silence_r;
  logic [SAMP_W-1:0]  stat_samples_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_lvl_r    <= ALARM_LEVEL_RST;
      resume_lvl_r   <= RESUME_LEVEL_RST;
      report_cap_r   <= REPORT_CAP_RST;
      silence_r      <= SILENCE_RST;
      stat_samples_r <= STAT_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (uam_cfg_idx_t'(cfg_index))
        CFG_ALARM_LEVEL:  alarm_lvl_r    <= cfg_data[LEVEL_W-1:0];
        CFG_RESUME_LEVEL: resume_lvl_r   <= cfg_data[LEVEL_W-1:0];
        CFG_REPORT_CAP:   report_cap_r   <= cfg_data[CAP_W-1:0];
        CFG_SILENCE:      silence_r      <= cfg_data;
        CFG_STAT_SAMPLES: stat_samples_r <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  uam_state_t state_r, state_nxt;

  logic                  in_acc;
  logic                  in_zero;
  logic [USED_W-1:0]     used_in, total_in;
  logic [USED_W-1:0]     used_r, total_r;
  logic [DIV_NUM_W-1:0]  prod_r;
  logic                  sat_r;
  logic [USAGE_W-1:0]    usage_r;
  logic [SUM_W-1:0]      avg_num_r;
  logic [SAMP_W-1:0]     avg_den_r;
  logic                  out_tvalid_r;
  logic                  out_load;
  logic                  stat_hit;

  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [USED_W-1:0]     div_den;
  uam_div_stat_t         div_stat;

  assign used_in  = in_tdata[USED_W-1:0];
  assign total_in = in_tdata[2*USED_W-1:USED_W];
  assign in_zero  = (used_in == '0) || (total_in == '0);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // Drop samples with a zero count right away.
        if (in_acc && !in_zero) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_QSTART;
      end
      ST_QSTART: begin
        if (sat_r) begin
          state_nxt = ST_UPDATE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_QWAIT;
        end
      end
      ST_QWAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = stat_hit ? ST_ASTART : ST_WRITE;
      end
      ST_ASTART: begin
        div_start = 1'b1;
        state_nxt = ST_AWAIT;
      end
      ST_AWAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // Hold the result until the output register is free.
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Share the divider between the usage quotient and the period average.
  assign div_num = (state_r == ST_ASTART) ? DIV_NUM_W'(avg_num_r) : prod_r;
  assign div_den = (state_r == ST_ASTART) ? USED_W'(avg_den_r) : total_r;

  uam_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Usage: used*25600/total, saturated. used >= total means at least 100 percent,
  // so the divider only sees used < total and its quotient fits 15 bits.
  // ---------------------------------------------------------------------------
  logic [DIV_NUM_W-1:0] used_ext;
  assign used_ext = DIV_NUM_W'(used_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      used_r  <= used_in;
      total_r <= total_in;
    end
    if (state_r == ST_MUL) begin
      // 25600 = 2**14 + 2**13 + 2**10
      prod_r <= (used_ext << 14) + (used_ext << 13) + (used_ext << 10);
      sat_r  <= (used_r >= total_r);
    end
    if (state_r == ST_QSTART && sat_r) begin
      usage_r <= FULL_SCALE;
    end else if (state_r == ST_QWAIT && div_stat.done) begin
      usage_r <= div_stat.quot;
    end
  end

  // ---------------------------------------------------------------------------
  // Alarm, silence window and period statistics
  // ---------------------------------------------------------------------------
  logic                  in_alarm_r;
  logic                  sil_run_r;
  logic [SAMP_W-1:0]     sil_cnt_r;
  logic [CAP_W-1:0]      reports_r;
  logic [SAMP_W-1:0]     period_r;
  logic [SUM_W-1:0]      sum_r;
  logic [USAGE_W-1:0]    min_r, max_r;
  logic [COUNT_BITS-1:0] raise_cnt_r, resume_cnt_r, dur_cnt_r;

  logic [USAGE_W-1:0]    alarm_thr, resume_thr;
  logic                  raise, clear, sil_start, report;
  logic                  in_alarm_nxt;
  logic [USAGE_W-1:0]    min_nxt, max_nxt;
  logic [SUM_W-1:0]      sum_nxt;
  logic [SAMP_W-1:0]     period_nxt;
  logic [COUNT_BITS-1:0] raise_cnt_nxt, resume_cnt_nxt, dur_cnt_nxt;
  logic                  sil_run_mid;
  logic [SAMP_W-1:0]     sil_cnt_mid, sil_cnt_nxt;
  logic                  sil_run_nxt;
  logic [ExtW-1:0]       raise_ext, resume_ext, dur_ext;

  assign alarm_thr  = {alarm_lvl_r, 8'h00};
  assign resume_thr = {resume_lvl_r, 8'h00};

  always_comb begin
    min_nxt    = (usage_r < min_r) ? usage_r : min_r;
    max_nxt    = (usage_r > max_r) ? usage_r : max_r;
    sum_nxt    = sum_r + SUM_W'(usage_r);
    period_nxt = (period_r != '1) ? period_r + 1'b1 : period_r;

    raise     = (usage_r >= alarm_thr) && !in_alarm_r;
    clear     = !raise && in_alarm_r && (usage_r < resume_thr);
    sil_start = raise && !sil_run_r;
    report    = sil_start && (reports_r < report_cap_r);
    in_alarm_nxt = raise | (in_alarm_r & ~clear);

    raise_cnt_nxt = raise_cnt_r;
    if (raise && raise_cnt_r != '1) begin
      raise_cnt_nxt = raise_cnt_r + 1'b1;
    end
    resume_cnt_nxt = resume_cnt_r;
    if (clear && resume_cnt_r != '1) begin
      resume_cnt_nxt = resume_cnt_r + 1'b1;
    end
    dur_cnt_nxt = dur_cnt_r;
    if (in_alarm_nxt && dur_cnt_r != '1) begin
      dur_cnt_nxt = dur_cnt_r + 1'b1;
    end

    // A fresh window starts at zero; a running one advances and closes at its end.
    sil_run_mid = sil_run_r | sil_start;
    sil_cnt_mid = sil_start ? '0 : sil_cnt_r;
    sil_cnt_nxt = sil_cnt_mid;
    sil_run_nxt = sil_run_mid;
    if (sil_run_mid) begin
      if (sil_cnt_mid != '1) begin
        sil_cnt_nxt = sil_cnt_mid + 1'b1;
      end
      if (sil_cnt_nxt >= silence_r) begin
        sil_run_nxt = 1'b0;
      end
    end

    // A zero period length acts as one: period_nxt is never zero.
    stat_hit = (period_nxt >= stat_samples_r);

    raise_ext  = ExtW'(raise_cnt_nxt);
    resume_ext = ExtW'(resume_cnt_nxt);
    dur_ext    = ExtW'(dur_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_alarm_r   <= 1'b0;
      sil_run_r    <= 1'b0;
      sil_cnt_r    <= '0;
      reports_r    <= '0;
      period_r     <= '0;
      sum_r        <= '0;
      min_r        <= FULL_SCALE;
      max_r        <= '0;
      raise_cnt_r  <= '0;
      resume_cnt_r <= '0;
      dur_cnt_r    <= '0;
    end else if (state_r == ST_UPDATE) begin
      in_alarm_r <= in_alarm_nxt;
      sil_run_r  <= sil_run_nxt;
      sil_cnt_r  <= sil_cnt_nxt;
      if (stat_hit) begin
        // Period closes: clear the statistics, keep alarm and window.
        reports_r    <= '0;
        period_r     <= '0;
        sum_r        <= '0;
        min_r        <= FULL_SCALE;
        max_r        <= '0;
        raise_cnt_r  <= '0;
        resume_cnt_r <= '0;
        dur_cnt_r    <= '0;
      end else begin
        reports_r    <= report ? reports_r + 1'b1 : reports_r;
        period_r     <= period_nxt;
        sum_r        <= sum_nxt;
        min_r        <= min_nxt;
        max_r        <= max_nxt;
        raise_cnt_r  <= raise_cnt_nxt;
        resume_cnt_r <= resume_cnt_nxt;
        dur_cnt_r    <= dur_cnt_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result staging and output register
  // ---------------------------------------------------------------------------
  logic                 res_alarm_r, res_report_r, res_resume_r, res_stat_r;
  logic [USAGE_W-1:0]   res_usage_r, res_min_r, res_max_r, res_avg_r;
  logic [STAT_W-1:0]    res_raise_r, res_resume_cnt_r, res_dur_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      res_usage_r  <= usage_r;
      res_alarm_r  <= in_alarm_nxt;
      res_report_r <= report;
      res_resume_r <= clear;
      res_stat_r   <= stat_hit;
      avg_num_r    <= sum_nxt;
      avg_den_r    <= period_nxt;
      // Statistics fields read zero outside a period end.
      res_min_r        <= stat_hit ? min_nxt : '0;
      res_max_r        <= stat_hit ? max_nxt : '0;
      res_raise_r      <= stat_hit ? raise_ext[STAT_W-1:0] : '0;
      res_resume_cnt_r <= stat_hit ? resume_ext[STAT_W-1:0] : '0;
      res_dur_r        <= stat_hit ? dur_ext[STAT_W-1:0] : '0;
      res_avg_r        <= '0;
    end else if (state_r == ST_AWAIT && div_stat.done) begin
      res_avg_r <= div_stat.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {1'b0, res_dur_r, res_resume_cnt_r, res_raise_r,
                      res_avg_r, res_max_r, res_min_r,
                      res_resume_r, res_report_r, res_alarm_r, res_usage_r};
      out_tuser_r <= res_stat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

// ----- hw/rtl/uam_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 15-bit quotient.
// The caller guarantees num < den * 2**15. Depends on uam_pkg.
`default_nettype none

module uam_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [uam_pkg::DIV_NUM_W-1:0]  num,
  input  logic [uam_pkg::USED_W-1:0]     den,
  output uam_pkg::uam_div_stat_t         stat
);
  import uam_pkg::*;

  localparam int CntW = $clog2(DIV_STEPS + 1);

  logic [USED_W-1:0]    rem_r;
  logic [USED_W-1:0]    den_r;
  logic [USAGE_W-1:0]   num_r;
  logic [USAGE_W-1:0]   quot_r;
  logic [CntW-1:0]      cnt_r;
  logic                 done_r;
  logic [USED_W:0]      trial;
  logic [USED_W:0]      diff;
  logic                 fit;

  // Shift in the next numerator bit and subtract when the divisor fits.
  assign trial = {rem_r, num_r[USAGE_W-1]};
  assign fit   = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CntW'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num[DIV_NUM_W-1:USAGE_W];
      num_r  <= num[USAGE_W-1:0];
      den_r  <= den;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= fit ? diff[USED_W-1:0] : trial[USED_W-1:0];
      num_r  <= {num_r[USAGE_W-2:0], 1'b0};
      quot_r <= {quot_r[USAGE_W-2:0], fit};
    end
  end

  assign stat.done = done_r;
  assign stat.quot = quot_r;

endmodule

`default_nettype wire

// ----- hw/rtl/uam_checker.sv -----
// Port-level checker for usage_alarm_monitor_with_stats, bound to the top level.
// Depends on uam_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module uam_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [uam_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [uam_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [uam_pkg::OUT_USER_W-1:0]  out_tuser
);
  import uam_pkg::*;

  // A stalled result stays offered.
  `UAM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped under stall")

  // A nonzero sample occupies the block for the next cycle.
  `UAM_ASSERT_NEXT(a_busy, in_tvalid && in_tready && (in_tdata[31:0] != 32'd0) && (in_tdata[63:32] != 32'd0), !in_tready, "ready after a live sample")

  // A reported raise leaves the block in alarm and is never a resume.
  `UAM_ASSERT_SAME(a_report, out_tvalid && out_tdata[16], out_tdata[15] && !out_tdata[17], "report without alarm")

  // Statistics fields read zero unless the period ended.
  `UAM_ASSERT_SAME(a_stat_zero, out_tvalid && !out_tuser[0], out_tdata[110:18] == 93'd0, "stats outside period end")

endmodule

bind usage_alarm_monitor_with_stats uam_checker u_uam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
